### hdl/hamming_encode_and_syndrome_assert.svh
// Assertion macros for the Hamming encode and syndrome block.
// Included by the top level; needs no package.
`ifndef HAMMING_ENCODE_AND_SYNDROME_ASSERT_SVH
`define HAMMING_ENCODE_AND_SYNDROME_ASSERT_SVH

`ifndef SYNTHESIS

// Condition that must hold in the same cycle.
`define HES_ASSERT_NOW(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("hes assertion failed");

// Antecedent in one cycle, consequent in the next.
`define HES_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hes assertion failed");

`else

`define HES_ASSERT_NOW(label, clk, rstn, expr)
`define HES_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

### hdl/hes_pkg.sv
// Package for the Hamming encode and syndrome block: beat types, command
// codes and elaboration-time helper functions. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hes_pkg;

    localparam int DATA_W = 64;
    localparam int SYN_W  = 7;
    localparam int PAR_W  = 3;
    localparam int CFG_W  = 6;
    localparam int LEN_W  = 7;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_CHECK  = 1'b1;

    localparam logic [CFG_W-1:0] DATA_BITS_RESET = 6'd4;

    typedef struct packed {
        logic              command;
        logic [DATA_W-1:0] data_word;
    } in_t;

    typedef struct packed {
        logic [DATA_W-1:0] code_word;
        logic [SYN_W-1:0]  syndrome;
        logic [PAR_W-1:0]  parity_count;
    } out_t;

    // Least r with 2^r >= n + r + 1.
    function automatic int parity_bits_for(input int n);
        int r;
        r = 1;
        for (int i = 0; i < 7; i++) begin
            if ((1 << r) < n + r + 1) begin
                r = r + 1;
            end
        end
        return r;
    endfunction

    // Largest data length whose codeword still fits in max_code positions.
    function automatic int max_data_bits(input int max_code);
        int best;
        best = 1;
        for (int n = 1; n < 64; n++) begin
            if (n + parity_bits_for(n) <= max_code) begin
                best = n;
            end
        end
        return best;
    endfunction

    function automatic bit is_pow2(input int x);
        return (x != 0) && ((x & (x - 1)) == 0);
    endfunction

    // Index of the data bit that lands at a non-power-of-two position.
    function automatic int data_index(input int pos);
        int cnt;
        cnt = 0;
        for (int p = 1; p < 128; p++) begin
            if (p < pos && !is_pow2(p)) begin
                cnt = cnt + 1;
            end
        end
        return cnt;
    endfunction

endpackage

`default_nettype wire

### hdl/hes_syndrome.sv
// Parity-group XOR trees: folds a codeword into its 7-bit position sum.
// Uses hes_pkg for the syndrome width.
`timescale 1ns / 1ps
`default_nettype none

module hes_syndrome #(
    parameter int WIDTH = 64
) (
    input  wire logic [WIDTH-1:0]             code_vec,
    output logic      [hes_pkg::SYN_W-1:0]    syndrome
);

    // Bit k of the result is the parity of every position with bit k set.
    always_comb begin
        syndrome = '0;
        for (int k = 0; k < hes_pkg::SYN_W; k++) begin
            for (int b = 0; b < WIDTH; b++) begin
                if ((((b + 1) >> k) & 1) != 0) begin
                    syndrome[k] = syndrome[k] ^ code_vec[b];
                end
            end
        end
    end

endmodule

`default_nettype wire

### hdl/hamming_encode_and_syndrome.sv
// Top level of the Hamming encode and syndrome block: three-stage pipeline.
// Depends on hes_pkg, hes_syndrome and hamming_encode_and_syndrome_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// The input channel (s_valid, s_ready, s_data) takes one beat per command:
// encode places the data bits at the non-power-of-two positions and fills in
// the parity bits; check folds a received codeword into its syndrome. Each
// input beat yields exactly one result beat on the output channel (m_valid,
// m_ready, m_data), which also reports the parity bit count.
// The data length is set through cfg_we and cfg_wdata; it must only be
// written while no beat is in flight. Out-of-range lengths are clamped: zero
// acts as one, and lengths whose codeword would exceed MAX_CODE_BITS act as
// the largest length that fits.
// A beat passes through three register stages (masking and bit placement,
// parity trees, result assembly) that move in step; m_valid rises once the
// beat reaches the last one. One beat is accepted every cycle while the
// receiver does not stall.
// When the receiver stalls, the whole pipeline holds and s_ready falls, so
// up to three beats wait inside without loss. Reset empties the pipeline and
// sets the data length back to four.

module hamming_encode_and_syndrome #(
    parameter int MAX_CODE_BITS = 64
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    input  wire logic                      cfg_we,
    input  wire logic [hes_pkg::CFG_W-1:0] cfg_wdata,

    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire hes_pkg::in_t              s_data,

    output logic                           m_valid,
    input  wire logic                      m_ready,
    output hes_pkg::out_t                  m_data
);

    localparam int MAX_DATA = hes_pkg::max_data_bits(MAX_CODE_BITS);
    localparam int PAR_MAX  = $clog2(MAX_CODE_BITS + 1);

    // ------------------------------------------------------------------
    // Configuration. The derived masks and parity count are worked out at
    // write time so that the datapath only has to apply them.
    // ------------------------------------------------------------------
    logic [hes_pkg::CFG_W-1:0]  cfg_src;
    logic [hes_pkg::LEN_W-1:0]  cfg_n;
    logic [hes_pkg::PAR_W-1:0]  cfg_r;
    logic [hes_pkg::LEN_W-1:0]  cfg_len;
    logic [hes_pkg::DATA_W-1:0] data_mask_next;
    logic [MAX_CODE_BITS-1:0]   code_mask_next;

    logic [hes_pkg::PAR_W-1:0]  parity_count_reg;
    logic [hes_pkg::DATA_W-1:0] data_mask_reg;
    logic [MAX_CODE_BITS-1:0]   code_mask_reg;

    always_comb begin
        cfg_src = aresetn ? cfg_wdata : hes_pkg::DATA_BITS_RESET;
        if (cfg_src == '0) begin
            cfg_n = hes_pkg::LEN_W'(1);
        end else if (int'(cfg_src) > MAX_DATA) begin
            cfg_n = hes_pkg::LEN_W'(MAX_DATA);
        end else begin
            cfg_n = hes_pkg::LEN_W'(cfg_src);
        end
        cfg_r   = hes_pkg::PAR_W'(hes_pkg::parity_bits_for(int'(cfg_n)));
        cfg_len = cfg_n + hes_pkg::LEN_W'(cfg_r);
        for (int d = 0; d < hes_pkg::DATA_W; d++) begin
            data_mask_next[d] = (hes_pkg::LEN_W'(d) < cfg_n);
        end
        for (int b = 0; b < MAX_CODE_BITS; b++) begin
            code_mask_next[b] = (hes_pkg::LEN_W'(b) < cfg_len);
        end
    end

    // Reset loads the default length through the same derivation.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            parity_count_reg <= cfg_r;
            data_mask_reg    <= data_mask_next;
            code_mask_reg    <= code_mask_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: all stages advance together whenever the output
    // register is empty or being drained.
    // ------------------------------------------------------------------
    logic pipe_en;
    logic stg1_valid_reg;
    logic stg2_valid_reg;
    logic out_valid_reg;

    assign pipe_en = !out_valid_reg || m_ready;
    assign s_ready = pipe_en;
    assign m_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg1_valid_reg <= 1'b0;
            stg2_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else if (pipe_en) begin
            stg1_valid_reg <= s_valid;
            stg2_valid_reg <= stg1_valid_reg;
            out_valid_reg  <= stg2_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: mask unused bits and, for encode, spread the data bits over
    // the non-power-of-two positions. Parity positions are left at zero,
    // so the same parity trees serve both commands.
    // ------------------------------------------------------------------
    logic [hes_pkg::DATA_W-1:0] data_masked;
    logic [MAX_CODE_BITS-1:0]   enc_vec;
    logic [MAX_CODE_BITS-1:0]   chk_vec;
    logic [MAX_CODE_BITS-1:0]   stg1_vec_next;
    logic [MAX_CODE_BITS-1:0]   stg1_vec_reg;
    logic                       stg1_cmd_reg;

    assign data_masked = s_data.data_word & data_mask_reg;

    for (genvar p = 1; p <= MAX_CODE_BITS; p++) begin : g_place
        if (hes_pkg::is_pow2(p)) begin : g_parity
            assign enc_vec[p-1] = 1'b0;
        end else begin : g_data
            localparam int DIDX = hes_pkg::data_index(p);
            assign enc_vec[p-1] = data_masked[DIDX];
        end
    end

    assign chk_vec       = s_data.data_word[MAX_CODE_BITS-1:0] & code_mask_reg;
    assign stg1_vec_next = (s_data.command == hes_pkg::CMD_CHECK) ? chk_vec : enc_vec;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            stg1_vec_reg <= stg1_vec_next;
            stg1_cmd_reg <= s_data.command;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: parity trees. For encode the result is the set of parity
    // bits; for check it is the syndrome.
    // ------------------------------------------------------------------
    logic [hes_pkg::SYN_W-1:0] stg2_syn_next;
    logic [hes_pkg::SYN_W-1:0] stg2_syn_reg;
    logic [MAX_CODE_BITS-1:0]  stg2_vec_reg;
    logic                      stg2_cmd_reg;

    hes_syndrome #(
        .WIDTH (MAX_CODE_BITS)
    ) u_syndrome (
        .code_vec (stg1_vec_reg),
        .syndrome (stg2_syn_next)
    );

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            stg2_syn_reg <= stg2_syn_next;
            stg2_vec_reg <= stg1_vec_reg;
            stg2_cmd_reg <= stg1_cmd_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: assemble the result beat. Parity bit k goes to position 2^k;
    // bits beyond the configured parity count are zero by construction.
    // ------------------------------------------------------------------
    logic [MAX_CODE_BITS-1:0] code_vec;
    hes_pkg::out_t            out_next;
    hes_pkg::out_t            out_reg;

    always_comb begin
        code_vec = stg2_vec_reg;
        for (int k = 0; k < PAR_MAX; k++) begin
            code_vec[(1 << k) - 1] = stg2_syn_reg[k];
        end
        out_next.parity_count = parity_count_reg;
        if (stg2_cmd_reg == hes_pkg::CMD_CHECK) begin
            out_next.code_word = '0;
            out_next.syndrome  = stg2_syn_reg;
        end else begin
            out_next.code_word = hes_pkg::DATA_W'(code_vec);
            out_next.syndrome  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
`include "hamming_encode_and_syndrome_assert.svh"

    // A stall must freeze the valid bits of every internal stage.
    `HES_ASSERT_NEXT(a_hold_v, aclk, aresetn, !pipe_en, $stable({stg1_valid_reg, stg2_valid_reg}))

    // A stall must also freeze the stage 1 vector and the stage 2 syndrome.
    `HES_ASSERT_NEXT(a_hold_d, aclk, aresetn, !pipe_en, $stable({stg1_vec_reg, stg2_syn_reg}))

    // A beat in the middle stage reaches the output register on advance.
    `HES_ASSERT_NEXT(a_stage_moves, aclk, aresetn, stg2_valid_reg && pipe_en, out_valid_reg)

    // The reported parity count is always a legal one.
    `HES_ASSERT_NOW(a_parity_range, aclk, aresetn, !m_valid || (m_data.parity_count >= 3'd2))

endmodule

`default_nettype wire
